### sv/dlarws_pkg.sv
// ----------------------------------------------------------------------------
// dlarws_pkg : shared definitions of the random walk step unit
// Field widths, command and register codes, payload structs and the helper
// that turns a grid size register into its usable maximum coordinate.
// ----------------------------------------------------------------------------
package dlarws_pkg;

    // Coordinates and register widths
    localparam int COORD_W  = 6;
    localparam int GRID_W   = 7;
    localparam int MARGIN_W = 6;
    localparam int CODE_W   = 2;

    // Largest map the 6-bit coordinates can reach
    localparam int COORD_SPAN = 64;

    // Default module parameters
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GRID_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN      = 2'd2;

    localparam logic [GRID_W-1:0]   RST_GRID_WIDTH  = 7'd64;
    localparam logic [GRID_W-1:0]   RST_GRID_HEIGHT = 7'd64;
    localparam logic [MARGIN_W-1:0] RST_MARGIN      = 6'd4;

    // Command kinds
    localparam logic [CODE_W-1:0] KIND_STEP  = 2'd0;
    localparam logic [CODE_W-1:0] KIND_START = 2'd1;
    localparam logic [CODE_W-1:0] KIND_READ  = 2'd2;
    localparam logic [CODE_W-1:0] KIND_SPARE = 2'd3;

    // Move codes; the unused code means no move
    localparam logic [CODE_W-1:0] MOVE_DEC   = 2'd0;
    localparam logic [CODE_W-1:0] MOVE_HOLD  = 2'd1;
    localparam logic [CODE_W-1:0] MOVE_INC   = 2'd2;
    localparam logic [CODE_W-1:0] MOVE_SPARE = 2'd3;

    // Respawn corners
    localparam logic [CODE_W-1:0] CORNER_MIN_MIN = 2'd0;
    localparam logic [CODE_W-1:0] CORNER_MIN_MAX = 2'd1;
    localparam logic [CODE_W-1:0] CORNER_MAX_MAX = 2'd2;
    localparam logic [CODE_W-1:0] CORNER_MAX_MIN = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]  kind;
        logic [CODE_W-1:0]  move_x_code;
        logic [CODE_W-1:0]  move_y_code;
        logic [CODE_W-1:0]  corner_pick;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } t_cmd;

    typedef struct packed {
        logic               stuck;
        logic               cell_value;
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
    } t_result;

    // Walk domain of one axis and the wrapped next position
    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [COORD_W-1:0] nxt;
    } t_axis;

    // Usable size minus one: register capped at the stored map, at least 1
    function automatic logic [COORD_W-1:0] eff_size_m1(
        input logic [GRID_W-1:0] sz_reg,
        input int                cap
    );
        int s;
        s = int'(sz_reg);
        if (s > cap) begin
            s = cap;
        end
        if (s < 1) begin
            s = 1;
        end
        return 6'(s - 1);
    endfunction

endpackage

### sv/dlarws_map_mem.sv
// ----------------------------------------------------------------------------
// dlarws_map_mem : crystal map storage
// One word per column, one bit per row; one write and one registered read
// port.
// ----------------------------------------------------------------------------
module dlarws_map_mem #(
    parameter int DEPTH = dlarws_pkg::DEF_MAX_COLUMNS,
    parameter int WIDTH = dlarws_pkg::DEF_MAX_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dlarws_axis.sv
// ----------------------------------------------------------------------------
// dlarws_axis : walk domain and wrapped move of one axis
// Widens the box by the margin, clips it to the grid and wraps a one-cell
// move to the opposite edge.
// ----------------------------------------------------------------------------
module dlarws_axis (
    input  logic [dlarws_pkg::COORD_W-1:0]  i_pos,
    input  logic [dlarws_pkg::CODE_W-1:0]   i_move,
    input  logic [dlarws_pkg::COORD_W-1:0]  i_box_min,
    input  logic [dlarws_pkg::COORD_W-1:0]  i_box_max,
    input  logic [dlarws_pkg::MARGIN_W-1:0] i_margin,
    input  logic [dlarws_pkg::COORD_W-1:0]  i_size_m1,
    output dlarws_pkg::t_axis               o_axis
);

    logic [dlarws_pkg::COORD_W-1:0] lo;
    logic [dlarws_pkg::COORD_W-1:0] hi;
    logic [dlarws_pkg::COORD_W:0]   hi_sum;
    // Positions below carry a bias of one so that minus one stays unsigned
    logic [dlarws_pkg::COORD_W:0]   pos_b;
    logic [dlarws_pkg::COORD_W:0]   lo_b;
    logic [dlarws_pkg::COORD_W:0]   hi_b;
    logic [dlarws_pkg::COORD_W:0]   step_b;

    always_comb begin
        lo     = (i_box_min >= i_margin) ? (i_box_min - i_margin) : '0;
        hi_sum = {1'b0, i_box_max} + {1'b0, i_margin};
        hi     = (hi_sum > {1'b0, i_size_m1}) ? i_size_m1 : hi_sum[dlarws_pkg::COORD_W-1:0];

        case (i_move)
            dlarws_pkg::MOVE_DEC:  step_b = 7'd0;
            dlarws_pkg::MOVE_INC:  step_b = 7'd2;
            default:               step_b = 7'd1;
        endcase

        pos_b = {1'b0, i_pos} + step_b;
        lo_b  = {1'b0, lo} + 7'd1;
        hi_b  = {1'b0, hi} + 7'd1;

        o_axis.lo = lo;
        o_axis.hi = hi;
        // Below the domain: jump to the top; above: jump to the bottom
        if (pos_b < lo_b) begin
            o_axis.nxt = hi;
        end else if (pos_b > hi_b) begin
            o_axis.nxt = lo;
        end else begin
            o_axis.nxt = 6'(pos_b - 7'd1);
        end
    end

endmodule

### sv/dla_random_walk_step_unit.sv
// ----------------------------------------------------------------------------
// dla_random_walk_step_unit : diffusion-limited aggregation step engine
// Keeps a one-bit crystal map in a column-wide memory and a walking cursor
// with the crystal's bounding box; starts crystals, walks, attaches, reads.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Handshake            Payload
//  -----------  ---  -------------------  --------------------------------
//  command      in   start / busy         i_cmd    (dlarws_pkg::t_cmd)
//  result       out  o_valid, 1 cycle     o_result (dlarws_pkg::t_result)
//  config       in   i_cfg_wr_en          i_cfg_index, i_cfg_wdata
//
//  A command transfers on a rising edge with start high and busy low.
//  A walk step reads the map and then decides; when the cursor attaches it
//  also reads the cursor's column and writes it back. A read fetches the
//  column, then reports; an unused kind reports without leaving idle.
//  A start sweeps all min(MAX_COLUMNS, 64) columns of the map, one per cycle.
//  After reset the same sweep runs with busy high, without a result.
//  The result strobe is high for exactly one cycle; the receiver cannot
//  stall, and the next command may transfer in that same cycle.
// ----------------------------------------------------------------------------
module dla_random_walk_step_unit #(
    parameter int MAX_COLUMNS = dlarws_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = dlarws_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  dlarws_pkg::t_cmd                  i_cmd,
    output logic                              o_valid,
    output dlarws_pkg::t_result               o_result,
    input  logic                              i_cfg_wr_en,
    input  logic [dlarws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dlarws_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // Only the first 64 columns and rows are ever addressed
    localparam int COLS = (MAX_COLUMNS < dlarws_pkg::COORD_SPAN) ?
                          MAX_COLUMNS : dlarws_pkg::COORD_SPAN;
    localparam int ROWS = (MAX_ROWS < dlarws_pkg::COORD_SPAN) ?
                          MAX_ROWS : dlarws_pkg::COORD_SPAN;
    localparam int XW   = $clog2(COLS);
    localparam int YW   = $clog2(ROWS);
    localparam int CW   = dlarws_pkg::COORD_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_ATTACH = 5'b01000,
        ST_READ   = 5'b10000
    } t_state;

    // Configuration registers
    logic [dlarws_pkg::GRID_W-1:0]   r_grid_width;
    logic [dlarws_pkg::GRID_W-1:0]   r_grid_height;
    logic [dlarws_pkg::MARGIN_W-1:0] r_margin;

    // Control and walk state
    t_state               r_state,   n_state;
    dlarws_pkg::t_cmd     r_cmd,     n_cmd;
    logic [CW-1:0]        r_nx,      n_nx;
    logic [CW-1:0]        r_ny,      n_ny;
    logic [CW-1:0]        r_wx,      n_wx;
    logic [CW-1:0]        r_wy,      n_wy;
    logic [CW-1:0]        r_bminx,   n_bminx;
    logic [CW-1:0]        r_bmaxx,   n_bmaxx;
    logic [CW-1:0]        r_bminy,   n_bminy;
    logic [CW-1:0]        r_bmaxy,   n_bmaxy;
    logic [XW-1:0]        r_clr_col, n_clr_col;
    logic                 r_seed_en, n_seed_en;
    logic                 r_valid,   n_valid;
    dlarws_pkg::t_result  r_out,     n_out;

    logic [CW-1:0]        w_m1;
    logic [CW-1:0]        h_m1;
    dlarws_pkg::t_axis    ax_x;
    dlarws_pkg::t_axis    ax_y;

    logic                 mem_we;
    logic [XW-1:0]        mem_waddr;
    logic [ROWS-1:0]      mem_wdata;
    logic [XW-1:0]        mem_raddr;
    logic [ROWS-1:0]      mem_rdata;
    logic [CW-1:0]        rd_col;
    logic                 hit;

    function automatic logic col_ok(input logic [CW-1:0] x);
        return {1'b0, x} < 7'(COLS);
    endfunction

    function automatic logic row_ok(input logic [CW-1:0] y);
        return {1'b0, y} < 7'(ROWS);
    endfunction

    function automatic logic [ROWS-1:0] row_bit(input logic [CW-1:0] y);
        logic [ROWS-1:0] v;
        v = '0;
        if (row_ok(y)) begin
            v[y[YW-1:0]] = 1'b1;
        end
        return v;
    endfunction

    // Map bit of a column word; cells off the stored map read as clear
    function automatic logic word_bit(
        input logic [ROWS-1:0] word,
        input logic [CW-1:0]   x,
        input logic [CW-1:0]   y
    );
        return col_ok(x) && row_ok(y) && word[y[YW-1:0]];
    endfunction

    // ------------------------------------------------------------------
    // Configuration: plain writes, unknown indexes dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= dlarws_pkg::RST_GRID_WIDTH;
            r_grid_height <= dlarws_pkg::RST_GRID_HEIGHT;
            r_margin      <= dlarws_pkg::RST_MARGIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dlarws_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata;
                dlarws_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata;
                dlarws_pkg::CFG_MARGIN:      r_margin      <= i_cfg_wdata[dlarws_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_m1 = dlarws_pkg::eff_size_m1(r_grid_width, COLS);
    assign h_m1 = dlarws_pkg::eff_size_m1(r_grid_height, ROWS);

    // ------------------------------------------------------------------
    // Domain and wrap of each axis; the box registers feed them, so in the
    // attach cycle they already give the corners of the grown domain
    // ------------------------------------------------------------------
    dlarws_axis u_axis_x (
        .i_pos     (r_wx),
        .i_move    (i_cmd.move_x_code),
        .i_box_min (r_bminx),
        .i_box_max (r_bmaxx),
        .i_margin  (r_margin),
        .i_size_m1 (w_m1),
        .o_axis    (ax_x)
    );

    dlarws_axis u_axis_y (
        .i_pos     (r_wy),
        .i_move    (i_cmd.move_y_code),
        .i_box_min (r_bminy),
        .i_box_max (r_bmaxy),
        .i_margin  (r_margin),
        .i_size_m1 (h_m1),
        .o_axis    (ax_y)
    );

    dlarws_map_mem #(
        .DEPTH (COLS),
        .WIDTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Clamp the read column so the memory is never addressed past its end
    assign mem_raddr = col_ok(rd_col) ? rd_col[XW-1:0] : '0;
    assign hit       = word_bit(mem_rdata, r_nx, r_ny);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_nx      = r_nx;
        n_ny      = r_ny;
        n_wx      = r_wx;
        n_wy      = r_wy;
        n_bminx   = r_bminx;
        n_bmaxx   = r_bmaxx;
        n_bminy   = r_bminy;
        n_bmaxy   = r_bmaxy;
        n_clr_col = r_clr_col;
        n_seed_en = r_seed_en;
        n_valid   = 1'b0;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_clr_col;
        mem_wdata = '0;
        rd_col    = r_wx;

        case (r_state)
            ST_IDLE: begin
                // Fetch the target column of a step, or the column to read
                rd_col = (i_cmd.kind == dlarws_pkg::KIND_READ) ? i_cmd.pos_x : ax_x.nxt;
                if (start) begin
                    n_cmd = i_cmd;
                    n_nx  = ax_x.nxt;
                    n_ny  = ax_y.nxt;
                    case (i_cmd.kind)
                        dlarws_pkg::KIND_STEP: begin
                            n_state = ST_CHECK;
                        end
                        dlarws_pkg::KIND_READ: begin
                            n_state = ST_READ;
                        end
                        dlarws_pkg::KIND_START: begin
                            // Saturate the seed into the grid; cursor and
                            // box collapse onto it
                            n_wx      = (i_cmd.pos_x > w_m1) ? w_m1 : i_cmd.pos_x;
                            n_wy      = (i_cmd.pos_y > h_m1) ? h_m1 : i_cmd.pos_y;
                            n_bminx   = n_wx;
                            n_bmaxx   = n_wx;
                            n_bminy   = n_wy;
                            n_bmaxy   = n_wy;
                            n_seed_en = 1'b1;
                            n_clr_col = '0;
                            n_state   = ST_CLEAR;
                        end
                        default: begin
                            // Unused kind: report the cursor, change nothing
                            n_valid = 1'b1;
                            n_out   = '{stuck: 1'b0, cell_value: 1'b0,
                                        cursor_x: r_wx, cursor_y: r_wy};
                        end
                    endcase
                end
            end

            ST_CLEAR: begin
                // Wipe one column per cycle, planting the seed on the way
                mem_we    = 1'b1;
                mem_waddr = r_clr_col;
                if (r_seed_en && (6'(r_clr_col) == r_wx) && col_ok(r_wx)) begin
                    mem_wdata = row_bit(r_wy);
                end
                if (r_clr_col == XW'(COLS - 1)) begin
                    n_state = ST_IDLE;
                    n_valid = r_seed_en;
                    n_out   = '{stuck: 1'b0, cell_value: 1'b0,
                                cursor_x: r_wx, cursor_y: r_wy};
                end else begin
                    n_clr_col = r_clr_col + 1'b1;
                end
            end

            ST_CHECK: begin
                // Target column is back; fetch the cursor's column in case
                // it has to join the crystal
                rd_col = r_wx;
                if (hit) begin
                    if (r_wx < r_bminx) n_bminx = r_wx;
                    if (r_wx > r_bmaxx) n_bmaxx = r_wx;
                    if (r_wy < r_bminy) n_bminy = r_wy;
                    if (r_wy > r_bmaxy) n_bmaxy = r_wy;
                    n_state = ST_ATTACH;
                end else begin
                    n_wx    = r_nx;
                    n_wy    = r_ny;
                    n_valid = 1'b1;
                    n_out   = '{stuck: 1'b0, cell_value: 1'b0,
                                cursor_x: r_nx, cursor_y: r_ny};
                    n_state = ST_IDLE;
                end
            end

            ST_ATTACH: begin
                // Set the cursor cell, then respawn at the chosen corner of
                // the grown domain
                mem_we    = col_ok(r_wx) && row_ok(r_wy);
                mem_waddr = r_wx[XW-1:0];
                mem_wdata = mem_rdata | row_bit(r_wy);
                case (r_cmd.corner_pick)
                    dlarws_pkg::CORNER_MIN_MIN: begin
                        n_wx = ax_x.lo;
                        n_wy = ax_y.lo;
                    end
                    dlarws_pkg::CORNER_MIN_MAX: begin
                        n_wx = ax_x.lo;
                        n_wy = ax_y.hi;
                    end
                    dlarws_pkg::CORNER_MAX_MAX: begin
                        n_wx = ax_x.hi;
                        n_wy = ax_y.hi;
                    end
                    default: begin
                        // max column, min row
                        n_wx = ax_x.hi;
                        n_wy = ax_y.lo;
                    end
                endcase
                n_valid = 1'b1;
                n_out   = '{stuck: 1'b1, cell_value: 1'b0,
                            cursor_x: n_wx, cursor_y: n_wy};
                n_state = ST_IDLE;
            end

            ST_READ: begin
                n_valid = 1'b1;
                n_out   = '{stuck: 1'b0,
                            cell_value: word_bit(mem_rdata, r_cmd.pos_x, r_cmd.pos_y),
                            cursor_x: r_wx, cursor_y: r_wy};
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing sweep without a seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_col <= '0;
            r_seed_en <= 1'b0;
            r_valid   <= 1'b0;
            r_wx      <= '0;
            r_wy      <= '0;
            r_bminx   <= '0;
            r_bmaxx   <= '0;
            r_bminy   <= '0;
            r_bmaxy   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_col <= n_clr_col;
            r_seed_en <= n_seed_en;
            r_valid   <= n_valid;
            r_wx      <= n_wx;
            r_wy      <= n_wy;
            r_bminx   <= n_bminx;
            r_bmaxx   <= n_bmaxx;
            r_bminy   <= n_bminy;
            r_bmaxy   <= n_bmaxy;
        end
    end

    // Payload: hold the latched command and the result word
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_nx  <= n_nx;
        r_ny  <= n_ny;
        r_out <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
